// ===== hw/rtl/text_console_writer_assert.svh =====
// assertion macros used by the console writer controller
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// shared constants, types and helpers of the text console writer
package tcw_pkg;

    // grid geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // character codes and attribute
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] TEXT_ATTR    = 8'd7;

    // request kinds
    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CELL_W-1:0] t_cell;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_DONE
    } t_state;

    // cell store write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_ZERO,
        WR_PUT,
        WR_SCROLL
    } t_wsel;

    typedef struct packed {
        t_wsel wsel;
        logic  capture;
        logic  exec;
        logic  sweep_clr;
        logic  sweep_inc;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic need_scroll;
        logic clear_end;
        logic scroll_end;
    } t_sts;

    // linear cell address of a row and column
    function automatic t_addr cell_addr(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        return t_addr'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

// ===== hw/rtl/tcw_if.sv =====
// request and response channel interfaces of the text console writer

// request channel
interface tcw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::ROW_W-1:0]    read_row;
    logic [tcw_pkg::COL_W-1:0]    read_col;

    modport source (output valid, req_type, char_code, read_row, read_col, input ready);
    modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

// response channel
interface tcw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::CHAR_W-1:0]   echo_char;
    logic [tcw_pkg::COL_W-1:0]    cursor_col;
    logic [tcw_pkg::ROW_W-1:0]    cursor_row;
    logic                         scrolled;
    logic [tcw_pkg::CHAR_W-1:0]   cell_char;
    logic [tcw_pkg::ATTR_W-1:0]   cell_attr;

    modport source (output valid, echo_char, cursor_col, cursor_row, scrolled,
                    cell_char, cell_attr, input ready);
    modport sink   (input valid, echo_char, cursor_col, cursor_row, scrolled,
                    cell_char, cell_attr, output ready);
endinterface

// ===== hw/rtl/tcw_dp.sv =====
// datapath: cell store, cursor, sweep counter and response register
module tcw_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcw_pkg::t_cmd              i_cmd,
    output tcw_pkg::t_sts              o_sts,
    input  logic                       i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]  i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]  i_read_col,
    output logic [tcw_pkg::CHAR_W-1:0] o_echo_char,
    output logic [tcw_pkg::COL_W-1:0]  o_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic                       o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0] o_cell_attr
);

    // cell store and its registered read data
    tcw_pkg::t_cell r_mem [tcw_pkg::CELLS];
    tcw_pkg::t_cell r_rdata;

    // captured transaction
    logic                       r_req_type;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::ROW_W-1:0]  r_rd_row;
    logic [tcw_pkg::COL_W-1:0]  r_rd_col;
    logic                       r_rd_hit;
    logic                       r_scrolled;

    // cursor and sweep counter
    logic [tcw_pkg::COL_W-1:0]  r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]  r_row, n_row;
    tcw_pkg::t_cnt              r_cnt, n_cnt;

    // response register
    logic [tcw_pkg::CHAR_W-1:0] r_out_echo;
    logic [tcw_pkg::COL_W-1:0]  r_out_col;
    logic [tcw_pkg::ROW_W-1:0]  r_out_row;
    logic                       r_out_scr;
    logic [tcw_pkg::CHAR_W-1:0] r_out_char;
    logic [tcw_pkg::ATTR_W-1:0] r_out_attr;

    logic [tcw_pkg::COL_W:0]    col_inc;
    logic [tcw_pkg::ROW_W:0]    row_inc;
    logic                       is_newline;
    logic                       advance;
    logic                       scroll;
    tcw_pkg::t_cnt              cnt_m1;
    tcw_pkg::t_cnt              rd_sum;
    logic                       we;
    logic                       re;
    tcw_pkg::t_addr             waddr;
    tcw_pkg::t_addr             raddr;
    tcw_pkg::t_cell             wdata;

    // cursor advance for a put
    always_comb begin
        col_inc    = {1'b0, r_col} + 1'b1;
        row_inc    = {1'b0, r_row} + 1'b1;
        is_newline = (r_char == tcw_pkg::NEWLINE_CODE);
        if (is_newline) begin
            advance = 1'b1;
            n_col   = '0;
        end else if (col_inc == (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
            advance = 1'b1;
            n_col   = '0;
        end else begin
            advance = 1'b0;
            n_col   = col_inc[tcw_pkg::COL_W-1:0];
        end
        scroll = advance && (row_inc == (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROWS));
        if (!advance) begin
            n_row = r_row;
        end else if (scroll) begin
            n_row = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        end else begin
            n_row = row_inc[tcw_pkg::ROW_W-1:0];
        end
    end

    // sweep counter
    always_comb begin
        if (i_cmd.sweep_clr) begin
            n_cnt = '0;
        end else if (i_cmd.sweep_inc) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // cell store port selection
    always_comb begin
        cnt_m1 = r_cnt - 1'b1;
        rd_sum = r_cnt + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS);
        we     = 1'b0;
        waddr  = r_cnt[tcw_pkg::ADDR_W-1:0];
        wdata  = '0;
        re     = 1'b0;
        raddr  = tcw_pkg::cell_addr(r_rd_row, r_rd_col);
        case (i_cmd.wsel)
            tcw_pkg::WR_NONE: begin
                we = 1'b0;
            end
            tcw_pkg::WR_ZERO: begin
                we = 1'b1;
            end
            tcw_pkg::WR_PUT: begin
                we    = !is_newline;
                waddr = tcw_pkg::cell_addr(r_row, r_col);
                wdata = {tcw_pkg::TEXT_ATTR, r_char};
            end
            tcw_pkg::WR_SCROLL: begin
                // copy writes the cell read in the cycle before, bottom row gets blanks
                we    = (r_cnt != '0);
                waddr = cnt_m1[tcw_pkg::ADDR_W-1:0];
                wdata = (r_cnt <= tcw_pkg::CNT_W'(tcw_pkg::COPY_CELLS)) ?
                        r_rdata : {tcw_pkg::TEXT_ATTR, tcw_pkg::SPACE_CODE};
                re    = (r_cnt < tcw_pkg::CNT_W'(tcw_pkg::COPY_CELLS));
                raddr = rd_sum[tcw_pkg::ADDR_W-1:0];
            end
            default: begin
                we = 1'b0;
            end
        endcase
        if (i_cmd.exec && r_req_type == tcw_pkg::REQ_READ) begin
            re = 1'b1;
        end
    end

    // cell store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    // cursor and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.exec && r_req_type == tcw_pkg::REQ_PUT) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // transaction capture and execute flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_char     <= i_char_code;
            r_rd_row   <= i_read_row;
            r_rd_col   <= i_read_col;
        end
        if (i_cmd.exec) begin
            r_scrolled <= scroll && (r_req_type == tcw_pkg::REQ_PUT);
            r_rd_hit   <= (r_rd_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) &&
                          (r_rd_col < tcw_pkg::COL_W'(tcw_pkg::COLUMNS));
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_col <= r_col;
            r_out_row <= r_row;
            if (r_req_type == tcw_pkg::REQ_PUT) begin
                r_out_echo <= r_char;
                r_out_scr  <= r_scrolled;
                r_out_char <= '0;
                r_out_attr <= '0;
            end else begin
                r_out_echo <= '0;
                r_out_scr  <= 1'b0;
                r_out_char <= r_rd_hit ? r_rdata[tcw_pkg::CHAR_W-1:0] : '0;
                r_out_attr <= r_rd_hit ? r_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_sts.is_read     = (r_req_type == tcw_pkg::REQ_READ);
        o_sts.need_scroll = scroll;
        o_sts.clear_end   = (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS - 1));
        o_sts.scroll_end  = (r_cnt == tcw_pkg::CNT_W'(tcw_pkg::CELLS));
    end

    assign o_echo_char  = r_out_echo;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;
    assign o_scrolled   = r_out_scr;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// controller: clear pass, transaction sequencing, scroll sweep and response handshake
`include "text_console_writer_assert.svh"

module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  tcw_pkg::t_sts i_sts,
    output tcw_pkg::t_cmd o_cmd
);

    tcw_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    tcw_pkg::t_cmd   cmd;

    // state and response valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        cmd.wsel   = tcw_pkg::WR_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                cmd.wsel      = tcw_pkg::WR_ZERO;
                cmd.sweep_inc = 1'b1;
                if (i_sts.clear_end) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            tcw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = tcw_pkg::S_EXEC;
                end
            end
            tcw_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = tcw_pkg::S_DONE;
                if (!i_sts.is_read) begin
                    cmd.wsel = tcw_pkg::WR_PUT;
                    if (i_sts.need_scroll) begin
                        cmd.sweep_clr = 1'b1;
                        n_state       = tcw_pkg::S_SCROLL;
                    end
                end
            end
            tcw_pkg::S_SCROLL: begin
                cmd.wsel      = tcw_pkg::WR_SCROLL;
                cmd.sweep_inc = !i_sts.scroll_end;
                if (i_sts.scroll_end) begin
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = tcw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::S_CLEAR;
            end
        endcase
    end

    // response valid: set on load, cleared when the transaction is taken
    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `TCW_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == tcw_pkg::S_EXEC, "accepted transaction not executed")
    `TCW_ASSERT_NOW(a_load_free, cmd.load_out, !r_out_valid || i_out_ready, "response overwritten before taken")
    `TCW_ASSERT_NOW(a_valid_src, $rose(r_out_valid), $past(cmd.load_out), "response valid without load")
    `TCW_ASSERT_NEXT(a_scroll_done, r_state == tcw_pkg::S_SCROLL && i_sts.scroll_end, r_state == tcw_pkg::S_DONE, "scroll sweep did not finish")

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// top level of the text console writer: controller plus datapath
//
//   channel | dir | handshake         | payload
//   i_req   | in  | valid / ready     | req_type, char_code, read_row, read_col
//   o_rsp   | out | valid / ready     | echo_char, cursor_col, cursor_row, scrolled,
//           |     |                   | cell_char, cell_attr
//
// a put or read goes from acceptance to a loaded response through accept, execute and
// load; the cell store read is registered between execute and load.
// a put that scrolls adds a sweep for the row copy and blank fill, one cell per cycle
// through the store.
// after reset a clearing pass zeroes the store; no transaction is accepted until it
// ends.
// one transaction is in work at a time; the next is accepted while the last response
// waits in the output register, and a stalled output only holds the load stage.
module text_console_writer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcw_req_if.sink      i_req,
    tcw_rsp_if.source    o_rsp
);

    tcw_pkg::t_cmd cmd;
    tcw_pkg::t_sts sts;

    // sequencing
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    tcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_req_type   (i_req.req_type),
        .i_char_code  (i_req.char_code),
        .i_read_row   (i_req.read_row),
        .i_read_col   (i_req.read_col),
        .o_echo_char  (o_rsp.echo_char),
        .o_cursor_col (o_rsp.cursor_col),
        .o_cursor_row (o_rsp.cursor_row),
        .o_scrolled   (o_rsp.scrolled),
        .o_cell_char  (o_rsp.cell_char),
        .o_cell_attr  (o_rsp.cell_attr)
    );

endmodule
